FILE: rtl/mqfe_pkg.sv
// Shared types, codes, constants and the CRC byte step of the meter query frame engine.
package mqfe_pkg;

	localparam int MAX_FRAME_DEF = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	localparam logic RK_TX = 1'b0;
	localparam logic RK_VERDICT = 1'b1;

	localparam logic [1:0] VERDICT_GOOD = 2'd0;
	localparam logic [1:0] VERDICT_SIZE = 2'd1;
	localparam logic [1:0] VERDICT_CRC = 2'd2;
	localparam logic [1:0] VERDICT_NONE = 2'd3;

	localparam logic [1:0] REG_METER_ADDRESS = 2'd0;
	localparam logic [1:0] REG_RESPONSE_TIMEOUT = 2'd1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_GOOD_RESIDUE = 16'h0F47;
	localparam logic [15:0] TIMEOUT_RESET = 16'd500;
	localparam logic [15:0] TICKS_MAX = 16'hFFFF;

	localparam logic [7:0] FRAME_STX = 8'h02;
	localparam logic [7:0] FRAME_LEN_BYTE = 8'h0E;
	localparam logic [7:0] FRAME_COM = 8'h01;
	localparam logic [7:0] FRAME_PASSWORD = 8'h00;
	localparam logic [8:0] MIN_RESP_LEN = 9'd3;

	localparam logic [3:0] IDX_STX = 4'd0;
	localparam logic [3:0] IDX_LEN = 4'd1;
	localparam logic [3:0] IDX_ADDR0 = 4'd2;
	localparam logic [3:0] IDX_ADDR1 = 4'd3;
	localparam logic [3:0] IDX_ADDR2 = 4'd4;
	localparam logic [3:0] IDX_ADDR3 = 4'd5;
	localparam logic [3:0] IDX_PW0 = 4'd6;
	localparam logic [3:0] IDX_PW1 = 4'd7;
	localparam logic [3:0] IDX_PW2 = 4'd8;
	localparam logic [3:0] IDX_PW3 = 4'd9;
	localparam logic [3:0] IDX_COM = 4'd10;
	localparam logic [3:0] IDX_CMD = 4'd11;
	localparam logic [3:0] IDX_CRC_LO = 4'd12;
	localparam logic [3:0] IDX_CRC_HI = 4'd13;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] command_id;
		logic [6:0] expected_length;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic result_kind;
		logic [7:0] tx_byte;
		logic last;
		logic [1:0] verdict;
		logic [31:0] good_count;
		logic [31:0] bad_count;
	} rsp_t;

	typedef struct packed {
		logic is_frame;
		logic [7:0] command_id;
		logic [31:0] meter_address;
		logic [1:0] verdict;
		logic [31:0] good_count;
		logic [31:0] bad_count;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: rtl/mqfe_front.sv
// Front part: takes input words, keeps the receive state and counters, and queues jobs.
module mqfe_front #(
	parameter int MAX_FRAME = mqfe_pkg::MAX_FRAME_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  mqfe_pkg::req_t         req,
	input  logic                   cfg_valid,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	input  mqfe_pkg::queue_status_t q_status,
	output logic                   push,
	output mqfe_pkg::job_t         push_job
);
	import mqfe_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME);

	logic [31:0] meter_address_q;
	logic [15:0] response_timeout_q;
	logic receiving_q;
	logic [CNT_W-1:0] bytes_seen_q;
	logic [CNT_W-1:0] target_length_q;
	logic [15:0] running_crc_q;
	logic [15:0] ticks_waited_q;
	logic [31:0] good_frames_q;
	logic [31:0] bad_frames_q;

	logic accept;
	logic [8:0] len9;
	logic [8:0] len_clamped;
	logic [15:0] crc_next;
	logic [CNT_W-1:0] seen_next;
	logic [15:0] ticks_next;
	logic byte_done;
	logic tick_done;
	logic [1:0] byte_verdict;

	assign req_ready = !q_status.full;
	assign accept = req_valid && req_ready;

	always_comb begin
		len9 = {2'b00, req.expected_length};
		if (len9 < MIN_RESP_LEN) begin
			len_clamped = MIN_RESP_LEN;
		end else if (len9 > MAX_LEN) begin
			len_clamped = MAX_LEN;
		end else begin
			len_clamped = len9;
		end
	end

	assign crc_next = crc_fold(running_crc_q, req.rx_byte);
	assign seen_next = bytes_seen_q + CNT_W'(1);
	assign byte_done = seen_next >= target_length_q;
	assign byte_verdict = ((crc_next ^ CRC_XOROUT) == CRC_GOOD_RESIDUE) ? VERDICT_GOOD
		: VERDICT_CRC;
	assign ticks_next = (ticks_waited_q < TICKS_MAX) ? ticks_waited_q + 16'd1 : ticks_waited_q;
	assign tick_done = ticks_next >= response_timeout_q;

	always_comb begin
		push = 1'b0;
		push_job = '0;
		push_job.meter_address = meter_address_q;
		push_job.command_id = req.command_id;
		if (accept) begin
			unique case (req.kind)
				KIND_START: begin
					push = !receiving_q;
					push_job.is_frame = 1'b1;
				end
				KIND_BYTE: begin
					push = receiving_q && byte_done;
					push_job.verdict = byte_verdict;
					push_job.good_count = (byte_verdict == VERDICT_GOOD) ? good_frames_q + 32'd1
						: good_frames_q;
					push_job.bad_count = (byte_verdict == VERDICT_GOOD) ? bad_frames_q
						: bad_frames_q + 32'd1;
				end
				KIND_TICK: begin
					push = receiving_q && tick_done;
					push_job.verdict = VERDICT_SIZE;
					push_job.good_count = good_frames_q;
					push_job.bad_count = bad_frames_q + 32'd1;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_address_q <= '0;
			response_timeout_q <= TIMEOUT_RESET;
			receiving_q <= 1'b0;
			bytes_seen_q <= '0;
			target_length_q <= '0;
			running_crc_q <= CRC_INIT;
			ticks_waited_q <= '0;
			good_frames_q <= '0;
			bad_frames_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_METER_ADDRESS) begin
					meter_address_q <= cfg_data;
				end else if (cfg_index == REG_RESPONSE_TIMEOUT) begin
					response_timeout_q <= cfg_data[15:0];
				end
			end
			if (accept) begin
				unique case (req.kind)
					KIND_START: begin
						if (!receiving_q) begin
							receiving_q <= 1'b1;
							bytes_seen_q <= '0;
							target_length_q <= CNT_W'(len_clamped);
							running_crc_q <= CRC_INIT;
							ticks_waited_q <= '0;
						end
					end
					KIND_BYTE: begin
						if (receiving_q) begin
							running_crc_q <= crc_next;
							bytes_seen_q <= seen_next;
							if (byte_done) begin
								receiving_q <= 1'b0;
								good_frames_q <= push_job.good_count;
								bad_frames_q <= push_job.bad_count;
							end
						end
					end
					KIND_TICK: begin
						if (receiving_q) begin
							ticks_waited_q <= ticks_next;
							if (tick_done) begin
								receiving_q <= 1'b0;
								bad_frames_q <= push_job.bad_count;
							end
						end
					end
					default: begin
						receiving_q <= receiving_q;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/mqfe_fifo.sv
// Short job queue between the front and back parts.
module mqfe_fifo #(
	parameter int DEPTH = mqfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  mqfe_pkg::job_t          push_job,
	input  logic                    pop,
	output mqfe_pkg::job_t          head,
	output mqfe_pkg::queue_status_t status
);
	import mqfe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	job_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head = entries_q[rd_ptr_q];
	assign status.full = count_q == DEPTH_CNT;
	assign status.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/mqfe_back.sv
// Back part: expands queued jobs into request frame bytes and verdict words.
module mqfe_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mqfe_pkg::job_t          head,
	input  mqfe_pkg::queue_status_t q_status,
	output logic                    pop,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output mqfe_pkg::rsp_t          rsp
);
	import mqfe_pkg::*;

	logic [3:0] idx_q;
	logic [15:0] crc_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic fire;
	logic [15:0] crc_base;
	logic [15:0] crc_out;
	logic [7:0] frame_byte;
	rsp_t word;

	assign fire = !q_status.empty && (!rsp_valid_q || rsp_ready);
	assign pop = fire && (!head.is_frame || idx_q == IDX_CRC_HI);
	assign crc_base = (idx_q == IDX_STX) ? CRC_INIT : crc_q;
	assign crc_out = crc_q ^ CRC_XOROUT;

	always_comb begin
		unique case (idx_q)
			IDX_STX: frame_byte = FRAME_STX;
			IDX_LEN: frame_byte = FRAME_LEN_BYTE;
			IDX_ADDR0: frame_byte = head.meter_address[7:0];
			IDX_ADDR1: frame_byte = head.meter_address[15:8];
			IDX_ADDR2: frame_byte = head.meter_address[23:16];
			IDX_ADDR3: frame_byte = head.meter_address[31:24];
			IDX_PW0, IDX_PW1, IDX_PW2, IDX_PW3: frame_byte = FRAME_PASSWORD;
			IDX_COM: frame_byte = FRAME_COM;
			IDX_CMD: frame_byte = head.command_id;
			IDX_CRC_LO: frame_byte = crc_out[7:0];
			IDX_CRC_HI: frame_byte = crc_out[15:8];
			default: frame_byte = 8'h00;
		endcase
	end

	always_comb begin
		word = '0;
		if (head.is_frame) begin
			word.result_kind = RK_TX;
			word.tx_byte = frame_byte;
			word.last = idx_q == IDX_CRC_HI;
		end else begin
			word.result_kind = RK_VERDICT;
			word.verdict = head.verdict;
			word.good_count = head.good_count;
			word.bad_count = head.bad_count;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= word;
			if (head.is_frame && idx_q < IDX_CRC_LO) begin
				crc_q <= crc_fold(crc_base, frame_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= IDX_STX;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
				if (head.is_frame) begin
					idx_q <= (idx_q == IDX_CRC_HI) ? IDX_STX : idx_q + 4'd1;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

FILE: rtl/meter_query_frame_engine.sv
// Top level of the meter query frame engine: front part, job queue and back part.
//
// The req channel takes one word per cycle: a start request, a byte received from the
// meter line, or one time tick. A start taken while idle sends a 14-byte enquiry frame
// out on the rsp channel, the last byte flagged, and opens a receive window; received
// bytes are folded into a CRC-16/X.25 until the expected length is reached, and one
// verdict word with the good and bad totals follows. Ticks end the window as a wrong
// size once the timeout is reached. Starts while receiving, and bytes or ticks while
// idle, are taken and dropped.
// Jobs pass through the job queue, and each rsp word is registered in the output
// register. A frame leaves at one byte per cycle while the rsp receiver is ready. The
// req channel accepts a word each cycle while the job queue has room, so it stalls
// when the queue fills up behind a frame; a stalled rsp receiver holds the output
// register and, through the queue, eventually the req channel. Registers are written
// through the cfg channel, which is always ready and should be used only while idle.
// Reset clears the receive state and both totals, and sets the timeout to 500 ticks.
module meter_query_frame_engine #(
	parameter int MAX_FRAME = mqfe_pkg::MAX_FRAME_DEF,
	parameter int QUEUE_DEPTH = mqfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mqfe_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mqfe_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);
	import mqfe_pkg::*;

	logic push;
	logic pop;
	job_t push_job;
	job_t head;
	queue_status_t q_status;

	assign cfg_ready = 1'b1;

	mqfe_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_status(q_status),
		.push(push),
		.push_job(push_job)
	);

	mqfe_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	mqfe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_status(q_status),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

endmodule

FILE: rtl/mqfe_checker.sv
// Port-level checks of the meter query frame engine, bound to the top level.
module mqfe_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input mqfe_pkg::rsp_t rsp
);
	import mqfe_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("Output word changed while stalled.");

	a_tx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == RK_TX |->
		rsp.verdict == VERDICT_GOOD && rsp.good_count == '0 && rsp.bad_count == '0)
		else $error("Transmit word carries verdict fields.");

	a_last_tx: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |-> rsp.result_kind == RK_TX)
		else $error("Last flag set on a verdict word.");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == RK_VERDICT |->
		rsp.tx_byte == 8'h00 && rsp.verdict != VERDICT_NONE)
		else $error("Verdict word malformed.");

endmodule

bind meter_query_frame_engine mqfe_checker u_mqfe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp(rsp)
);
